@@ rtl/utfs_pkg.sv @@
// Shared types and constants for the UART transmit FIFO serializer.
package utfs_pkg;

    // Item operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // 8N1 frame: start bit, 8 data bits LSB first, stop bit
    localparam int FRAME_BITS = 10;
    localparam int FRAME_CNT_W = 4;
    localparam logic [FRAME_CNT_W-1:0] FRAME_FULL = FRAME_CNT_W'(FRAME_BITS);
    localparam logic [FRAME_CNT_W-1:0] FRAME_LAST_IDX = FRAME_CNT_W'(FRAME_BITS - 1);
    localparam logic [FRAME_CNT_W-1:0] FRAME_STOP = FRAME_CNT_W'(1);

    localparam logic START_LEVEL = 1'b0;
    localparam logic STOP_LEVEL = 1'b1;
    localparam logic IDLE_LEVEL = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
        logic empty_next;
    } fifo_stat_t;

    typedef struct packed {
        logic pop;
        logic idle_next;
    } frame_ctl_t;

endpackage

@@ rtl/utfs_in_if.sv @@
// Input channel: push or bit-tick items.
interface utfs_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

@@ rtl/utfs_out_if.sv @@
// Output channel: one result per accepted item.
interface utfs_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic accepted;
    logic all_sent;

    modport source (output valid, output line_level, output accepted, output all_sent,
                    input ready);
    modport sink (input valid, input line_level, input accepted, input all_sent,
                  output ready);
endinterface

@@ rtl/utfs_fifo.sv @@
// Ring FIFO: byte store in a synchronous memory plus read and write pointers.
module utfs_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_en,
    input  logic [7:0]           push_data,
    input  logic                 pop_en,
    output logic [7:0]           rdata,
    output utfs_pkg::fifo_stat_t stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rdata_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PTR_W'(1);

    assign wr_ptr_next = push_en ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = pop_en ? rd_ptr_inc : rd_ptr_reg;

    assign stat.full       = (wr_ptr_inc == rd_ptr_reg);
    assign stat.empty      = (wr_ptr_reg == rd_ptr_reg);
    assign stat.empty_next = (wr_ptr_next == rd_ptr_next);

    assign rdata = rdata_reg;

    // Push and pop never come in the same cycle; a popped entry was
    // written in an earlier cycle, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop_en)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

endmodule

@@ rtl/utfs_frame.sv @@
// Frame serializer: bit counter over the popped byte and the line register.
module utfs_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_en,
    input  logic                 fifo_empty,
    input  logic [7:0]           rdata,
    output logic                 line_next,
    output utfs_pkg::frame_ctl_t ctl
);

    logic [utfs_pkg::FRAME_CNT_W-1:0] remain_reg;
    logic [utfs_pkg::FRAME_CNT_W-1:0] remain_next;
    logic [2:0]                       bit_idx;
    logic                             line_reg;
    logic                             shift_bit;
    logic                             shifting;

    // remain counts bits not yet driven; zero means frame register is empty.
    // Data bits are read from the memory output register, which holds still
    // for the whole frame since the next pop waits for the frame to end.
    assign shifting = tick_en && (remain_reg != '0);
    assign ctl.pop  = tick_en && (remain_reg == '0) && !fifo_empty;
    assign bit_idx  = 3'(utfs_pkg::FRAME_LAST_IDX - remain_reg);

    always_comb
    begin
        if (remain_reg == utfs_pkg::FRAME_FULL)
        begin
            shift_bit = utfs_pkg::START_LEVEL;
        end
        else if (remain_reg == utfs_pkg::FRAME_STOP)
        begin
            shift_bit = utfs_pkg::STOP_LEVEL;
        end
        else
        begin
            shift_bit = rdata[bit_idx];
        end
    end

    always_comb
    begin
        remain_next = remain_reg;
        if (shifting)
        begin
            remain_next = remain_reg - utfs_pkg::FRAME_CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            remain_next = utfs_pkg::FRAME_FULL;
        end
    end

    assign line_next     = shifting ? shift_bit : line_reg;
    assign ctl.idle_next = (remain_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            line_reg   <= utfs_pkg::IDLE_LEVEL;
        end
        else
        begin
            remain_reg <= remain_next;
            line_reg   <= line_next;
        end
    end

endmodule

@@ rtl/uart_tx_fifo_serializer_top.sv @@
// Top level of the 8N1 UART transmitter with ring FIFO.
//
//   channel | dir | payload                          | role
//   --------+-----+----------------------------------+------------------------------
//   item    | in  | operation, data_byte             | push a byte or one bit tick
//   result  | out | line_level, accepted, all_sent   | one result per item
//
// One item per clock; an item updates whichever of pointers, frame counter and
// line register it affects as it is transferred; its result sits in the output
// register the cycle after. The byte store is a one-port-each synchronous RAM.
// Reset: pointers and frame counter cleared, line high; store left unwritten.
// A held result stalls the input only while result.ready is low.
module uart_tx_fifo_serializer_top #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    utfs_in_if.sink    item,
    utfs_out_if.source result
);

    utfs_pkg::fifo_stat_t fifo_stat;
    utfs_pkg::frame_ctl_t frame_ctl;

    logic       item_xfer;
    logic       push_en;
    logic       tick_en;
    logic       line_next;
    logic [7:0] rdata;

    logic out_valid_reg;
    logic line_level_reg;
    logic accepted_reg;
    logic all_sent_reg;

    assign item.ready = !out_valid_reg || result.ready;
    assign item_xfer  = item.valid && item.ready;
    assign push_en    = item_xfer && (item.operation == utfs_pkg::OP_PUSH) && !fifo_stat.full;
    assign tick_en    = item_xfer && (item.operation == utfs_pkg::OP_TICK);

    utfs_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push_data (item.data_byte),
        .pop_en    (frame_ctl.pop),
        .rdata     (rdata),
        .stat      (fifo_stat)
    );

    utfs_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (tick_en),
        .fifo_empty (fifo_stat.empty),
        .rdata      (rdata),
        .line_next  (line_next),
        .ctl        (frame_ctl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            out_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            line_level_reg <= line_next;
            accepted_reg   <= push_en;
            all_sent_reg   <= fifo_stat.empty_next && frame_ctl.idle_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.line_level = line_level_reg;
    assign result.accepted   = accepted_reg;
    assign result.all_sent   = all_sent_reg;

endmodule
